// ===== rtl/core/sdd_pkg.sv =====
`default_nettype none

package sdd_pkg;

	// widest operand the ports carry
	localparam int unsigned WIDE_BITS = 96;
	// quotient bits kept on the result
	localparam int unsigned QUOT_BITS = 193;
	// decimal scale width
	localparam int unsigned SCALE_BITS = 5;
	// bits of one decimal digit (0..9)
	localparam int unsigned DIGIT_BITS = 4;

	typedef struct packed {
		logic [63:0]           dividend_lo;
		logic [31:0]           dividend_hi;
		logic [63:0]           divisor_lo;
		logic [31:0]           divisor_hi;
		logic [SCALE_BITS-1:0] start_scale;
	} cmd_t;

	typedef struct packed {
		logic [63:0]           quotient_w0;
		logic [63:0]           quotient_w1;
		logic [63:0]           quotient_w2;
		logic                  quotient_w3;
		logic [63:0]           remainder_lo;
		logic [31:0]           remainder_hi;
		logic [SCALE_BITS-1:0] final_scale;
		logic                  divide_by_zero;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_MUL,
		ST_DIG,
		ST_ACC,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/scaled_decimal_divider_unit.sv =====
`default_nettype none

// scaled decimal divider: computes floor(N * 10^k / D) and N * 10^k mod D for a
// 96-bit dividend N and divisor D, where k is the number of decimal digit steps
// taken from start_scale until the remainder is zero or the scale reaches
// MAX_SCALE. one command is in flight at a time: cmd_ready is high only while
// the sequencer is idle. a command first runs a bit-serial restoring division
// of N by D, one bit per cycle, then each decimal step scales by ten, makes
// four trial subtractions for the digit and accumulates the digit. every
// subtraction and compare goes through one shared wide subtract and compare
// unit. a command with nothing to iterate (zero dividend, start scale at or
// above MAX_SCALE, or a zero divisor) goes straight to the result without the
// division; unless the divisor is zero, its quotient is then zero and its
// remainder is the dividend. the result sits in an output register, so the
// next command is taken while an earlier result still waits for its transfer.
// a zero divisor returns divide_by_zero with every other field zero.
// dividend and divisor bits at or above OPERAND_BITS are ignored.
module scaled_decimal_divider_unit #(
	parameter int unsigned MAX_SCALE    = 29,
	parameter int unsigned OPERAND_BITS = 96
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_ready,
	input  wire sdd_pkg::cmd_t cmd,
	output logic              res_valid,
	input  wire logic         res_ready,
	output sdd_pkg::res_t     res
);

	localparam int unsigned OW    = OPERAND_BITS;
	// remainder register holds ten times a value below the divisor
	localparam int unsigned RW    = OPERAND_BITS + sdd_pkg::DIGIT_BITS;
	localparam int unsigned QW    = sdd_pkg::QUOT_BITS;
	localparam int unsigned SW    = sdd_pkg::SCALE_BITS;
	localparam int unsigned WB    = sdd_pkg::WIDE_BITS;
	localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
	localparam int unsigned SH_W  = $clog2(sdd_pkg::DIGIT_BITS);

	localparam logic [SW-1:0]    SCALE_LIMIT = SW'(MAX_SCALE);
	localparam logic [CNT_W-1:0] PRE_LAST    = CNT_W'(OPERAND_BITS - 1);
	localparam logic [CNT_W-1:0] DIG_FIRST   = CNT_W'(sdd_pkg::DIGIT_BITS - 1);

	// sequencer
	sdd_pkg::state_t state_q, state_d;
	logic            res_load;

	// working registers
	logic [OW-1:0]                  n_q;      // dividend bits still to shift in
	logic [OW-1:0]                  d_q;      // divisor
	logic [RW-1:0]                  rem_q;    // running remainder
	logic [QW-1:0]                  quo_q;    // running quotient
	logic [sdd_pkg::DIGIT_BITS-1:0] dig_q;    // digit being built
	logic [SW-1:0]                  scale_q;
	logic [CNT_W-1:0]               cnt_q;    // bit count in pre-division, digit bit in steps
	logic                           div0_q;

	// output register
	logic          res_valid_q;
	sdd_pkg::res_t res_q;

	// masked operands from the command
	logic [WB-1:0] dvd_full, dvr_full;
	logic [OW-1:0] dvd, dvr;
	logic          cmd_div0, cmd_skip;

	assign dvd_full = {cmd.dividend_hi, cmd.dividend_lo};
	assign dvr_full = {cmd.divisor_hi, cmd.divisor_lo};
	assign dvd      = dvd_full[OW-1:0];
	assign dvr      = dvr_full[OW-1:0];
	assign cmd_div0 = (dvr == '0);
	assign cmd_skip = (dvd == '0) || (cmd.start_scale >= SCALE_LIMIT);

	// shared subtract and compare unit
	// pre-division: shifted remainder against the divisor
	// digit steps: remainder against divisor times 8, 4, 2, 1
	logic [RW-1:0] sub_a, sub_b, sub_diff;
	logic          sub_borrow, sub_fits;

	always_comb begin
		if (state_q == sdd_pkg::ST_PRE) begin
			sub_a = {rem_q[RW-2:0], n_q[OW-1]};
			sub_b = RW'(d_q);
		end else begin
			sub_a = rem_q;
			sub_b = RW'(d_q) << cnt_q[SH_W-1:0];
		end
		{sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
		sub_fits = !sub_borrow;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			sdd_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					// nothing to iterate: go straight to the result
					if (cmd_div0 || cmd_skip) begin
						state_d = sdd_pkg::ST_FIN;
					end else begin
						state_d = sdd_pkg::ST_PRE;
					end
				end
			end
			sdd_pkg::ST_PRE: begin
				if (cnt_q == '0) begin
					state_d = sdd_pkg::ST_MUL;
				end
			end
			sdd_pkg::ST_MUL: begin
				state_d = sdd_pkg::ST_DIG;
			end
			sdd_pkg::ST_DIG: begin
				if (cnt_q == '0) begin
					state_d = sdd_pkg::ST_ACC;
				end
			end
			sdd_pkg::ST_ACC: begin
				// stop on an exact result or at the scale limit
				if ((rem_q == '0) || (scale_q >= SCALE_LIMIT)) begin
					state_d = sdd_pkg::ST_FIN;
				end else begin
					state_d = sdd_pkg::ST_MUL;
				end
			end
			sdd_pkg::ST_FIN: begin
				// wait for the output register to be free
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = sdd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdd_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			sdd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					n_q     <= dvd;
					d_q     <= dvr;
					// the division starts from an empty remainder; with no step
					// the dividend itself is the remainder
					rem_q   <= cmd_skip ? RW'(dvd) : '0;
					quo_q   <= '0;
					scale_q <= cmd.start_scale;
					div0_q  <= cmd_div0;
					cnt_q   <= PRE_LAST;
				end
			end
			sdd_pkg::ST_PRE: begin
				// one restoring division bit: quotient bit enters at the bottom
				n_q   <= {n_q[OW-2:0], 1'b0};
				rem_q <= sub_fits ? sub_diff : sub_a;
				quo_q <= {quo_q[QW-2:0], sub_fits};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			sdd_pkg::ST_MUL: begin
				// times ten as 8x + 2x
				rem_q   <= RW'({rem_q, 3'b000}) + RW'({rem_q, 1'b0});
				quo_q   <= QW'({quo_q, 3'b000}) + QW'({quo_q, 1'b0});
				scale_q <= scale_q + SW'(1);
				dig_q   <= '0;
				cnt_q   <= DIG_FIRST;
			end
			sdd_pkg::ST_DIG: begin
				if (sub_fits) begin
					rem_q <= sub_diff;
				end
				dig_q <= {dig_q[sdd_pkg::DIGIT_BITS-2:0], sub_fits};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			sdd_pkg::ST_ACC: begin
				quo_q <= quo_q + QW'(dig_q);
			end
			sdd_pkg::ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	logic [WB-1:0] rem_wide;
	sdd_pkg::res_t res_d;

	assign rem_wide = WB'(rem_q);

	always_comb begin
		res_d = '0;
		if (div0_q) begin
			res_d.divide_by_zero = 1'b1;
		end else begin
			res_d.quotient_w0  = quo_q[63:0];
			res_d.quotient_w1  = quo_q[127:64];
			res_d.quotient_w2  = quo_q[191:128];
			res_d.quotient_w3  = quo_q[192];
			res_d.remainder_lo = rem_wide[63:0];
			res_d.remainder_hi = rem_wide[95:64];
			res_d.final_scale  = scale_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/sdd_check.sv =====
`default_nettype none

module sdd_check #(
	parameter int unsigned MAX_SCALE = 29
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_ready,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire sdd_pkg::res_t res
);

	localparam logic [sdd_pkg::SCALE_BITS-1:0] SCALE_LIMIT = sdd_pkg::SCALE_BITS'(MAX_SCALE);

	// one command at a time: busy right after a command transfer
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd_ready high right after a command transfer");

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed before its transfer");

	// zero divisor clears every other field
	a_div0_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_by_zero |->
			res.quotient_w0 == '0 && res.quotient_w1 == '0 &&
			res.quotient_w2 == '0 && res.quotient_w3 == 1'b0 &&
			res.remainder_lo == '0 && res.remainder_hi == '0 &&
			res.final_scale == '0)
		else $error("divide_by_zero result with nonzero fields");

	// an inexact result only stops at the scale limit
	a_rem_scale: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.divide_by_zero &&
			(res.remainder_lo != '0 || res.remainder_hi != '0) |->
			res.final_scale >= SCALE_LIMIT)
		else $error("nonzero remainder below the scale limit");

endmodule

bind scaled_decimal_divider_unit sdd_check #(.MAX_SCALE(MAX_SCALE)) u_sdd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
